/* rtl/dqpi_pkg.sv */
// Shared constants, codes and types for the positional-insert deque.
package dqpi_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;

  // Fixed field widths of the item and result ports.
  localparam int OP_W     = 2;
  localparam int IN_ID_W  = 16;
  localparam int POS_W    = 8;
  localparam int STAT_W   = 2;

  localparam int OUT_ID_W = ID_WIDTH + 1;
  localparam int OCC_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CMP_W    = (POS_W > OCC_W) ? POS_W : OCC_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_PUSH   = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_RESP,
    CS_RESP_HELD
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

/* rtl/dqpi_ctrl.sv */
// Controller state machine: sequences capture, update and result handoff.
module dqpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dqpi_pkg::dp_cmd_t cmd
);
  import dqpi_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = CS_RESP;
      end
      CS_RESP: begin
        // A new beat may be captured while the finished result waits.
        in_ready  = 1'b1;
        out_valid = 1'b1;
        if (in_valid && out_ready) begin
          state_nxt = CS_EXEC;
        end else if (in_valid) begin
          state_nxt = CS_RESP_HELD;
        end else if (out_ready) begin
          state_nxt = CS_IDLE;
        end
      end
      CS_RESP_HELD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = CS_EXEC;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
    cmd.capture = in_valid & in_ready;
  end

endmodule

/* rtl/dqpi_datapath.sv */
// Datapath: shift-capable entry row, fill count, rear tracking and result registers.
module dqpi_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dqpi_pkg::dp_cmd_t                   cmd,
  input  logic [dqpi_pkg::OP_W-1:0]           in_op,
  input  logic [dqpi_pkg::IN_ID_W-1:0]        in_ident,
  input  logic [dqpi_pkg::POS_W-1:0]          in_position,
  output logic signed [dqpi_pkg::OUT_ID_W-1:0] res_front,
  output logic signed [dqpi_pkg::OUT_ID_W-1:0] res_rear,
  output logic [dqpi_pkg::OCC_W-1:0]          res_occupancy,
  output logic [dqpi_pkg::STAT_W-1:0]         res_status
);
  import dqpi_pkg::*;

  logic [ID_WIDTH-1:0] slots_r   [DEPTH];
  logic [ID_WIDTH-1:0] slots_nxt [DEPTH];
  logic [OCC_W-1:0]    fill_r, fill_nxt;
  logic [ID_WIDTH-1:0] rear_r, rear_nxt;

  op_t                 op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [POS_W-1:0]    pos_r;

  logic                is_full, is_empty, do_insert, do_remove;
  logic [CMP_W-1:0]    pos_m1, fill_ext, idx_wide;
  logic [IDX_W-1:0]    idx;
  status_t             status_nxt;

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_op);
      id_r  <= ID_WIDTH'(in_ident);
      pos_r <= in_position;
    end
  end

  always_comb begin
    is_full   = (fill_r == OCC_W'(DEPTH));
    is_empty  = (fill_r == '0);
    do_remove = (op_r == OP_REMOVE) && !is_empty;
    do_insert = (op_r != OP_REMOVE) && !is_full;

    // Insert position: one-based, clamped to the front and to the rear.
    fill_ext = CMP_W'(fill_r);
    pos_m1   = CMP_W'(pos_r) - CMP_W'(1);
    case (op_r)
      OP_APPEND: idx_wide = fill_ext;
      OP_PUSH:   idx_wide = '0;
      OP_INSERT: begin
        if (pos_r <= POS_W'(1)) begin
          idx_wide = '0;
        end else if (pos_m1 > fill_ext) begin
          idx_wide = fill_ext;
        end else begin
          idx_wide = pos_m1;
        end
      end
      default:   idx_wide = '0;
    endcase
    idx = IDX_W'(idx_wide);

    if (op_r == OP_REMOVE) begin
      status_nxt = is_empty ? ST_EMPTY : ST_DONE;
    end else begin
      status_nxt = is_full ? ST_FULL : ST_DONE;
    end

    // Each cell picks its own neighbor, the new identifier, or holds.
    for (int k = 0; k < DEPTH; k++) begin
      slots_nxt[k] = slots_r[k];
      if (do_remove) begin
        if (k < DEPTH - 1) begin
          slots_nxt[k] = slots_r[(k < DEPTH - 1) ? k + 1 : k];
        end
      end else if (do_insert) begin
        if (IDX_W'(k) == idx) begin
          slots_nxt[k] = id_r;
        end else if (k > 0 && IDX_W'(k) > idx) begin
          slots_nxt[k] = slots_r[(k > 0) ? k - 1 : k];
        end
      end
    end

    fill_nxt = fill_r;
    rear_nxt = rear_r;
    if (do_remove) begin
      fill_nxt = fill_r - OCC_W'(1);
    end else if (do_insert) begin
      fill_nxt = fill_r + OCC_W'(1);
      if (idx_wide == fill_ext) begin
        rear_nxt = id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      slots_r <= slots_nxt;
      rear_r  <= rear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.execute) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_occupancy <= fill_nxt;
      res_status    <= status_nxt;
      if (fill_nxt == '0) begin
        res_front <= '1;
        res_rear  <= '1;
      end else begin
        res_front <= OUT_ID_W'(slots_nxt[0]);
        res_rear  <= OUT_ID_W'(rear_nxt);
      end
    end
  end

endmodule

/* rtl/deque_with_positional_insert_top.sv */
// Top level of the bounded deque with positional insert.
// Each beat carries one operation (append at rear, push at front, insert at a
// one-based position, remove front) and yields one result beat with the front
// and rear identifiers (-1 when empty), the entry count and a status code.
// An item is captured at its accepting edge and the entry row is updated at the
// next edge, which also registers the result beat. No item is accepted during
// the controller's update step, but a new item may be accepted while a result
// is still waiting to be taken. No clearing pass follows reset.
module deque_with_positional_insert_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dqpi_pkg::OP_W-1:0]            in_op,
  input  logic [dqpi_pkg::IN_ID_W-1:0]         in_ident,
  input  logic [dqpi_pkg::POS_W-1:0]           in_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dqpi_pkg::OUT_ID_W-1:0] out_front_ident,
  output logic signed [dqpi_pkg::OUT_ID_W-1:0] out_rear_ident,
  output logic [dqpi_pkg::OCC_W-1:0]           out_occupancy,
  output logic [dqpi_pkg::STAT_W-1:0]          out_status
);
  import dqpi_pkg::*;

  dp_cmd_t cmd;

  dqpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dqpi_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_op         (in_op),
    .in_ident      (in_ident),
    .in_position   (in_position),
    .res_front     (out_front_ident),
    .res_rear      (out_rear_ident),
    .res_occupancy (out_occupancy),
    .res_status    (out_status)
  );

endmodule

/* rtl/dqpi_checker.sv */
// Port-level checker for the deque top level, with its bind statement.
module dqpi_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 out_valid,
  input  logic signed [dqpi_pkg::OUT_ID_W-1:0] out_front_ident,
  input  logic signed [dqpi_pkg::OUT_ID_W-1:0] out_rear_ident,
  input  logic [dqpi_pkg::OCC_W-1:0]           out_occupancy,
  input  logic [dqpi_pkg::STAT_W-1:0]          out_status
);
  import dqpi_pkg::*;

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_empty_ids: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_occupancy == '0) |->
      (out_front_ident == '1 && out_rear_ident == '1))
    else $error("empty queue must report -1 identifiers");

  a_held_ids: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_occupancy != '0) |->
      (!out_front_ident[OUT_ID_W-1] && !out_rear_ident[OUT_ID_W-1]))
    else $error("non-empty queue reported a negative identifier");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_occupancy == OCC_W'(DEPTH))
    else $error("full status without a full queue");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> out_occupancy == '0)
    else $error("empty status with entries held");

endmodule

bind deque_with_positional_insert_top dqpi_checker u_dqpi_checker (.*);
